// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file sfh_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge while reset is released.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/sfh_pkg.sv -----
package sfh_pkg;

    localparam int unsigned MaxShards = 64;
    localparam logic [15:0] MaxCapture = 16'd65535;
    localparam logic [15:0] MinCapture = 16'd34;
    localparam logic [15:0] EthHdrLen = 16'd14;
    localparam logic [15:0] TypeVlan = 16'h8100;
    localparam logic [15:0] TypeQinq = 16'h88a8;
    localparam logic [15:0] TypeIpv4 = 16'h0800;
    localparam logic [7:0] ProtoTcp = 8'd6;
    localparam logic [7:0] ProtoUdp = 8'd17;
    localparam logic [63:0] MixC1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MixC2 = 64'hc4ceb9fe1a85ec53;

    localparam logic [2:0] StOk = 3'd0;
    localparam logic [2:0] StShort = 3'd1;
    localparam logic [2:0] StNotIp = 3'd2;
    localparam logic [2:0] StProto = 3'd3;
    localparam logic [2:0] StHdrLen = 3'd4;

    // Header fields handed from the parser to the hash engine.
    typedef struct packed {
        logic [2:0] status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_l4_port;
        logic [15:0] dst_l4_port;
        logic [7:0] proto;
    } frame_info_t;

endpackage

// ----- hw/rtl/sfh_parser.sv -----
module sfh_parser
    import sfh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output frame_info_t info
);

    logic [15:0] pos_reg, pos_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] ipoff_reg, ipoff_next;
    logic [5:0]  ihl_reg, ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] sa_reg, sa_next, da_reg, da_next;
    logic [15:0] sp_reg, sp_next, dp_reg, dp_next;
    logic [7:0]  prev_reg, prev_next;

    logic [15:0] rel;
    logic [15:0] caplen, remain;
    logic        is_tag;

    logic [15:0] ipoff_next_v, type_v;
    logic [5:0]  ihl_v;
    logic [7:0]  proto_v;

    assign is_tag = (type_reg == TypeVlan) || (type_reg == TypeQinq);
    assign rel = pos_reg - ipoff_reg;

    always_comb
    begin
        pos_next = pos_reg;
        type_next = type_reg;
        ipoff_next = ipoff_reg;
        ihl_next = ihl_reg;
        proto_next = proto_reg;
        sa_next = sa_reg;
        da_next = da_reg;
        sp_next = sp_reg;
        dp_next = dp_reg;
        prev_next = prev_reg;
        if (take && pos_reg != MaxCapture)
        begin
            pos_next = pos_reg + 16'd1;
            prev_next = data_byte;
            if (pos_reg == 16'd13)
            begin
                type_next = {prev_reg, data_byte};
            end
            else if (pos_reg >= EthHdrLen)
            begin
                if (is_tag)
                begin
                    if (pos_reg == ipoff_reg + 16'd3)
                    begin
                        type_next = {prev_reg, data_byte};
                        ipoff_next = ipoff_reg + 16'd4;
                    end
                end
                else if (type_reg == TypeIpv4 && pos_reg >= ipoff_reg)
                begin
                    if (rel == 16'd0) ihl_next = {data_byte[3:0], 2'b00};
                    if (rel == 16'd9) proto_next = data_byte;
                    if (rel == 16'd12) sa_next[7:0] = data_byte;
                    if (rel == 16'd13) sa_next[15:8] = data_byte;
                    if (rel == 16'd14) sa_next[23:16] = data_byte;
                    if (rel == 16'd15) sa_next[31:24] = data_byte;
                    if (rel == 16'd16) da_next[7:0] = data_byte;
                    if (rel == 16'd17) da_next[15:8] = data_byte;
                    if (rel == 16'd18) da_next[23:16] = data_byte;
                    if (rel == 16'd19) da_next[31:24] = data_byte;
                    if (rel == {10'd0, ihl_reg}) sp_next[7:0] = data_byte;
                    if (rel == {10'd0, ihl_reg} + 16'd1) sp_next[15:8] = data_byte;
                    if (rel == {10'd0, ihl_reg} + 16'd2) dp_next[7:0] = data_byte;
                    if (rel == {10'd0, ihl_reg} + 16'd3) dp_next[15:8] = data_byte;
                end
            end
        end
        if (take && last_byte)
        begin
            pos_next = '0;
            type_next = '0;
            ipoff_next = EthHdrLen;
            ihl_next = '0;
            proto_next = '0;
            sa_next = '0;
            da_next = '0;
            sp_next = '0;
            dp_next = '0;
            prev_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            type_reg <= '0;
            ipoff_reg <= EthHdrLen;
            ihl_reg <= '0;
            proto_reg <= '0;
            sa_reg <= '0;
            da_reg <= '0;
            sp_reg <= '0;
            dp_reg <= '0;
            prev_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            type_reg <= type_next;
            ipoff_reg <= ipoff_next;
            ihl_reg <= ihl_next;
            proto_reg <= proto_next;
            sa_reg <= sa_next;
            da_reg <= da_next;
            sp_reg <= sp_next;
            dp_reg <= dp_next;
            prev_reg <= prev_next;
        end
    end

    // Frame summary as it stands after the current byte is taken.
    assign caplen = (pos_reg != MaxCapture) ? pos_reg + 16'd1 : pos_reg;
    assign remain = (caplen >= ipoff_next_v) ? caplen - ipoff_next_v : 16'd0;

    // Values after this byte, before the end-of-frame clear.
    always_comb
    begin
        ipoff_next_v = ipoff_reg;
        type_v = type_reg;
        ihl_v = ihl_reg;
        proto_v = proto_reg;
        info.src_addr = sa_reg;
        info.dst_addr = da_reg;
        info.src_l4_port = sp_reg;
        info.dst_l4_port = dp_reg;
        if (pos_reg != MaxCapture)
        begin
            if (pos_reg == 16'd13)
            begin
                type_v = {prev_reg, data_byte};
            end
            else if (pos_reg >= EthHdrLen)
            begin
                if (is_tag)
                begin
                    if (pos_reg == ipoff_reg + 16'd3)
                    begin
                        type_v = {prev_reg, data_byte};
                        ipoff_next_v = ipoff_reg + 16'd4;
                    end
                end
                else if (type_reg == TypeIpv4 && pos_reg >= ipoff_reg)
                begin
                    if (rel == 16'd0) ihl_v = {data_byte[3:0], 2'b00};
                    if (rel == 16'd9) proto_v = data_byte;
                    if (rel == 16'd15) info.src_addr[31:24] = data_byte;
                    if (rel == 16'd19) info.dst_addr[31:24] = data_byte;
                    if (rel == {10'd0, ihl_reg} + 16'd1) info.src_l4_port[15:8] = data_byte;
                    if (rel == {10'd0, ihl_reg} + 16'd2) info.dst_l4_port[7:0] = data_byte;
                    if (rel == {10'd0, ihl_reg} + 16'd3) info.dst_l4_port[15:8] = data_byte;
                end
            end
        end
        info.proto = proto_v;
        if (caplen < MinCapture)
            info.status = StShort;
        else if (type_v != TypeIpv4 || remain < 16'd20)
            info.status = StNotIp;
        else if (proto_v != ProtoTcp && proto_v != ProtoUdp)
            info.status = StProto;
        else if (ihl_v < 6'd20 || {10'd0, ihl_v} + 16'd4 > remain)
            info.status = StHdrLen;
        else
            info.status = StOk;
    end

endmodule

// ----- hw/rtl/sfh_engine.sv -----
module sfh_engine
    import sfh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  frame_info_t info,
    input  logic [6:0]  shard_count,
    output logic        busy,
    output logic        done,
    output logic [2:0]  status,
    output logic [5:0]  shard,
    output logic [63:0] flow_hash
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_X1 = 4'd1;
    localparam logic [3:0] S_M1 = 4'd2;
    localparam logic [3:0] S_X2 = 4'd3;
    localparam logic [3:0] S_M2 = 4'd4;
    localparam logic [3:0] S_X3 = 4'd5;
    localparam logic [3:0] S_MOD = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    logic [3:0]  state_reg, state_next;
    logic        word_reg;
    logic [1:0]  part_reg;
    logic [63:0] x_reg, wb_reg, acc_reg, h_reg, rem_reg;
    logic [6:0]  bit_reg;
    logic [6:0]  n_reg;
    logic [2:0]  st_reg;

    // One 32x32 partial product per cycle, shared by both multiplies.
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] cst;
    logic [63:0] addend;
    logic [6:0]  rtrial;

    assign cst = (state_reg == S_M1) ? MixC1 : MixC2;
    always_comb
    begin
        mul_a = part_reg[1] ? x_reg[63:32] : x_reg[31:0];
        mul_b = (part_reg == 2'd1) ? cst[63:32] : cst[31:0];
        if (part_reg == 2'd2) mul_b = cst[31:0];
        prod = mul_a * mul_b;
        addend = (part_reg == 2'd0) ? prod : {prod[31:0], 32'd0};
    end

    assign rtrial = {rem_reg[5:0], h_reg[bit_reg[5:0]]};

    logic [31:0] lo_a, hi_a;
    logic [15:0] lo_p, hi_p;
    logic        swap;
    assign swap = (info.src_addr > info.dst_addr) ||
                  (info.src_addr == info.dst_addr && info.src_l4_port > info.dst_l4_port);
    assign lo_a = swap ? info.dst_addr : info.src_addr;
    assign hi_a = swap ? info.src_addr : info.dst_addr;
    assign lo_p = swap ? info.dst_l4_port : info.src_l4_port;
    assign hi_p = swap ? info.src_l4_port : info.dst_l4_port;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = (info.status == StOk) ? S_X1 : S_DONE;
            S_X1: state_next = S_M1;
            S_M1: if (part_reg == 2'd2) state_next = S_X2;
            S_X2: state_next = S_M2;
            S_M2: if (part_reg == 2'd2) state_next = S_X3;
            S_X3: state_next = word_reg ? S_MOD : S_X1;
            S_MOD: if (bit_reg == 7'd0) state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                part_reg <= '0;
                word_reg <= 1'b0;
                st_reg <= info.status;
                h_reg <= '0;
                rem_reg <= '0;
                x_reg <= {hi_a, lo_a};
                wb_reg <= {24'd0, info.proto, hi_p, lo_p};
                n_reg <= (shard_count == 7'd0) ? 7'd1 :
                         (shard_count > 7'(MaxShards)) ? 7'(MaxShards) : shard_count;
            end
            S_X1, S_X2:
            begin
                x_reg <= x_reg ^ (x_reg >> 33);
                acc_reg <= '0;
                part_reg <= '0;
            end
            S_M1, S_M2:
            begin
                if (part_reg == 2'd2)
                    x_reg <= acc_reg + addend;
                else
                    acc_reg <= acc_reg + addend;
                part_reg <= (part_reg == 2'd2) ? 2'd0 : part_reg + 2'd1;
            end
            S_X3:
            begin
                h_reg <= h_reg ^ x_reg ^ (x_reg >> 33);
                x_reg <= wb_reg;
                word_reg <= 1'b1;
                bit_reg <= 7'd63;
            end
            S_MOD:
            begin
                // Restoring remainder, one hash bit per cycle.
                rem_reg <= (rtrial >= n_reg) ? {57'd0, rtrial - n_reg} : {57'd0, rtrial};
                bit_reg <= bit_reg - 7'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign status = st_reg;
    assign shard = (st_reg == StOk) ? rem_reg[5:0] : 6'd0;
    assign flow_hash = (st_reg == StOk) ? h_reg : 64'd0;

endmodule

// ----- hw/rtl/symmetric_flow_hash_steering.sv -----
// Symmetric flow-hash steering.
// Slave stream: one frame byte per transaction, s_axis_tlast on the final byte.
// Master stream: one result transaction per frame, issued after the last byte.
// Bytes other than the last are taken at one per cycle with no result.
// On the last byte the header checks are resolved; for a steered frame a shared
// 32x32 multiplier then runs the two fmix64 finalizers (three partial products per
// multiply), then a bit-serial remainder unit takes the hash modulo shard_count
// (clamped to 1..64), one bit a cycle. A rejected frame skips both. The engine
// steps X1, M1, X2, M2, X3 for each word, then MOD, then DONE, which registers the
// result and raises m_axis_tvalid; s_axis_tready is low meanwhile and until the
// result transaction completes, so a stalled receiver stalls input and no byte of
// the next frame is taken before then.
// Reset clears the parser and sets shard_count to 4; cfg_wr_en writes it.
module symmetric_flow_hash_steering
    import sfh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // status, shard, flow_hash, zero pad
);

    logic [6:0] shard_count_reg;
    logic       take, busy, done;
    logic [2:0] status;
    logic [5:0] shard;
    logic [63:0] flow_hash;
    frame_info_t info;
    logic       out_valid_reg;
    logic [72:0] out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shard_count_reg <= 7'd4;
        else if (cfg_wr_en)
            shard_count_reg <= cfg_wr_data;
    end

    assign s_axis_tready = !busy && !out_valid_reg;
    assign take = s_axis_tvalid && s_axis_tready;

    sfh_parser u_parser (
        .clk(clk), .rst_n(rst_n), .take(take),
        .data_byte(s_axis_tdata), .last_byte(s_axis_tlast), .info(info)
    );

    sfh_engine u_engine (
        .clk(clk), .rst_n(rst_n), .start(take && s_axis_tlast), .info(info),
        .shard_count(shard_count_reg), .busy(busy), .done(done),
        .status(status), .shard(shard), .flow_hash(flow_hash)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_reg <= {flow_hash, shard, status};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, out_reg};

endmodule

// ----- hw/rtl/sfh_checker.sv -----
`include "assert_macros.svh"
module sfh_checker
    import sfh_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    `ASSERT_IMPL(a_no_take_while_out, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `ASSERT_NEXT(a_last_blocks, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast,
        !s_axis_tready)
    `ASSERT_IMPL(a_status_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[2:0] <= StHdrLen)
    `ASSERT_IMPL(a_zero_on_reject, clk, rst_n, m_axis_tvalid && m_axis_tdata[2:0] != StOk,
        m_axis_tdata[72:3] == '0)

endmodule

bind symmetric_flow_hash_steering sfh_checker u_sfh_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ----- verif/tb_symmetric_flow_hash_steering.sv -----
`timescale 1ns / 1ps

module tb_symmetric_flow_hash_steering;
    import sfh_pkg::*;

    localparam int LimitCycles = 200000;

    typedef struct {
        logic [2:0]  status;
        logic [5:0]  shard;
        logic [63:0] flow_hash;
    } steer_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // status, shard, flow_hash, zero pad

    symmetric_flow_hash_steering u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Predictor state.
    logic [6:0]  shard_setting;
    logic [15:0] pos_cnt;
    logic [15:0] frame_type;
    logic [15:0] ip_ofs;
    logic [5:0]  ihl_bytes;
    logic [7:0]  proto_seen;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  last_seen_byte;

    steer_result_t pending_steer[$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  idle_enable;
    bit  hold_sink;
    int  hold_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] mix64(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ (x >> 33);
        x = x * 64'hff51afd7ed558ccd;
        x = x ^ (x >> 33);
        x = x * 64'hc4ceb9fe1a85ec53;
        x = x ^ (x >> 33);
        return x;
    endfunction

    task automatic clear_parser();
        pos_cnt = '0;
        frame_type = '0;
        ip_ofs = EthHdrLen;
        ihl_bytes = '0;
        proto_seen = '0;
        saddr = '0;
        daddr = '0;
        sport = '0;
        dport = '0;
        last_seen_byte = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        int p;
        int rel;
        p = pos_cnt;
        if (p == 13)
            frame_type = {last_seen_byte, b};
        else if (p >= 14)
        begin
            if (frame_type == TypeVlan || frame_type == TypeQinq)
            begin
                if (p == int'(ip_ofs) + 3)
                begin
                    frame_type = {last_seen_byte, b};
                    ip_ofs = ip_ofs + 16'd4;
                end
            end
            else if (frame_type == TypeIpv4 && p >= int'(ip_ofs))
            begin
                rel = p - int'(ip_ofs);
                if (rel == 0) ihl_bytes = {b[3:0], 2'b00};
                if (rel == 9) proto_seen = b;
                if (rel >= 12 && rel <= 15) saddr[8*(rel-12) +: 8] = saddr[8*(rel-12) +: 8] | b;
                if (rel >= 16 && rel <= 19) daddr[8*(rel-16) +: 8] = daddr[8*(rel-16) +: 8] | b;
                if (rel == int'(ihl_bytes)) sport[7:0] = b;
                if (rel == int'(ihl_bytes) + 1) sport[15:8] = b;
                if (rel == int'(ihl_bytes) + 2) dport[7:0] = b;
                if (rel == int'(ihl_bytes) + 3) dport[15:8] = b;
            end
        end
        last_seen_byte = b;
    endtask

    // Advances the predictor by one byte and queues the result on a last byte.
    task automatic predict_steering(input logic [7:0] b, input logic last);
        steer_result_t r;
        int caplen;
        int remain;
        logic [31:0] lo_a, hi_a;
        logic [15:0] lo_p, hi_p;
        logic [63:0] h;
        int n;
        if (pos_cnt < MaxCapture)
        begin
            parse_byte(b);
            pos_cnt = pos_cnt + 16'd1;
        end
        if (last)
        begin
            caplen = pos_cnt;
            remain = (caplen >= int'(ip_ofs)) ? caplen - int'(ip_ofs) : 0;
            r.shard = '0;
            r.flow_hash = '0;
            if (caplen < int'(MinCapture))
                r.status = StShort;
            else if (frame_type != TypeIpv4 || remain < 20)
                r.status = StNotIp;
            else if (proto_seen != ProtoTcp && proto_seen != ProtoUdp)
                r.status = StProto;
            else if (ihl_bytes < 20 || int'(ihl_bytes) + 4 > remain)
                r.status = StHdrLen;
            else
            begin
                lo_a = saddr; hi_a = daddr; lo_p = sport; hi_p = dport;
                if (lo_a > hi_a || (lo_a == hi_a && lo_p > hi_p))
                begin
                    lo_a = daddr; hi_a = saddr; lo_p = dport; hi_p = sport;
                end
                h = mix64({hi_a, lo_a}) ^ mix64({24'd0, proto_seen, hi_p, lo_p});
                n = shard_setting;
                if (n == 0) n = 1;
                if (n > MaxShards) n = MaxShards;
                r.shard = 6'(h % 64'(n));
                r.flow_hash = h;
                r.status = StOk;
            end
            pending_steer.insert(pending_steer.size(), r);
            clear_parser();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Sink side: random stalls plus an optional long hold-off.
    initial
    begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_sink = 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 16);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        steer_result_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_steer.size() == 0)
            begin
                report_mismatch("unexpected result", m_axis_tdata[72:9], 64'd0);
            end
            else
            begin
                w = pending_steer.pop_front();
                if (m_axis_tdata[2:0] !== w.status)
                    report_mismatch("status", 64'(m_axis_tdata[2:0]), 64'(w.status));
                if (m_axis_tdata[8:3] !== w.shard)
                    report_mismatch("shard", 64'(m_axis_tdata[8:3]), 64'(w.shard));
                if (m_axis_tdata[72:9] !== w.flow_hash)
                    report_mismatch("flow_hash", m_axis_tdata[72:9], w.flow_hash);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LimitCycles)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_steering(b, last);
    endtask

    task automatic send_frame(input logic [7:0] fr[$]);
        foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_steer.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_shard_count(input logic [6:0] v);
        go_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shard_setting = v;
        @(posedge clk);
    endtask

    // Builds a frame; tags, ethertype, ihl, protocol and total length shape which check it meets.
    function automatic void build_frame(output logic [7:0] fr[$], input int tags,
                                        input logic [15:0] etype, input logic [3:0] ihl,
                                        input logic [7:0] proto, input int total);
        fr = {};
        for (int i = 0; i < 12; i++) fr.insert(fr.size(), 8'($urandom));
        for (int t = 0; t < tags; t++)
        begin
            logic [15:0] tt;
            tt = $urandom_range(0, 1) ? TypeVlan : TypeQinq;
            fr.insert(fr.size(), tt[15:8]);
            fr.insert(fr.size(), tt[7:0]);
            fr.insert(fr.size(), 8'($urandom));
            fr.insert(fr.size(), 8'($urandom));
        end
        fr.insert(fr.size(), etype[15:8]);
        fr.insert(fr.size(), etype[7:0]);
        fr.insert(fr.size(), {4'h4, ihl});
        for (int i = 1; i < 9; i++) fr.insert(fr.size(), 8'($urandom));
        fr.insert(fr.size(), proto);
        while (fr.size() < total) fr.insert(fr.size(), 8'($urandom));
        while (fr.size() > total) fr.delete(fr.size() - 1);
    endfunction

    function automatic void good_frame(output logic [7:0] fr[$], input int tags);
        int ihl;
        ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        build_frame(fr, tags, TypeIpv4, 4'(ihl), $urandom_range(0, 1) ? ProtoTcp : ProtoUdp,
                    14 + 4 * tags + ihl * 4 + 4 + $urandom_range(0, 20));
    endfunction

    task automatic test_directed();
        logic [7:0] fr[$];
        // Valid TCP or UDP frame, then its reversed direction (ports at offset 34 when ihl is 5).
        good_frame(fr, 0);
        send_frame(fr);
        for (int i = 0; i < 4; i++)
        begin
            {fr[26 + i], fr[30 + i]} = {fr[30 + i], fr[26 + i]};
        end
        {fr[34], fr[35], fr[36], fr[37]} = {fr[36], fr[37], fr[34], fr[35]};
        send_frame(fr);
        // Equal addresses so the port order decides.
        good_frame(fr, 1);
        for (int i = 0; i < 4; i++) fr[34 + i] = fr[30 + i];
        send_frame(fr);
        // Single byte, 33 bytes, and all-ones / all-zeros content.
        fr = {8'hff};
        send_frame(fr);
        build_frame(fr, 0, TypeIpv4, 4'd5, ProtoTcp, 33);
        send_frame(fr);
        fr = {};
        for (int i = 0; i < 60; i++) fr.insert(fr.size(), 8'hff);
        send_frame(fr);
        fr = {};
        for (int i = 0; i < 60; i++) fr.insert(fr.size(), 8'h00);
        send_frame(fr);
        build_frame(fr, 0, 16'h86dd, 4'd5, ProtoTcp, 60);
        send_frame(fr);
        build_frame(fr, 0, TypeIpv4, 4'd5, 8'd1, 60);
        send_frame(fr);
        build_frame(fr, 0, TypeIpv4, 4'd4, ProtoUdp, 60);
        send_frame(fr);
        // Ports missing: header fits, port bytes do not.
        build_frame(fr, 0, TypeIpv4, 4'd5, ProtoUdp, 36);
        send_frame(fr);
        // Three tags, frame cut short inside the IPv4 header.
        build_frame(fr, 3, TypeIpv4, 4'd5, ProtoTcp, 40);
        while (fr.size() > 35) fr.delete(fr.size() - 1);
        send_frame(fr);
        good_frame(fr, 4);
        send_frame(fr);
        // Remaining IPv4 bytes under 20 after tags.
        build_frame(fr, 2, TypeIpv4, 4'd5, ProtoTcp, 40);
        send_frame(fr);
    endtask

    task automatic test_random(input int n_items);
        logic [7:0] fr[$];
        int sent;
        int kind;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                good_frame(fr, $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
            else if (kind == 7)
                build_frame(fr, $urandom_range(0, 2),
                            $urandom_range(0, 1) ? TypeIpv4 : 16'($urandom),
                            4'($urandom), 8'($urandom), $urandom_range(34, 80));
            else if (kind == 8)
                build_frame(fr, 0, TypeIpv4, 4'd5, ProtoTcp, $urandom_range(1, 40));
            else
            begin
                fr = {};
                repeat ($urandom_range(1, 70)) fr.insert(fr.size(), 8'($urandom));
            end
            send_frame(fr);
            sent += fr.size();
        end
    endtask

    task automatic test_backpressure();
        logic [7:0] fr[$];
        hold_cycles = 400;
        hold_sink = 1'b1;
        repeat (4)
        begin
            good_frame(fr, 0);
            send_frame(fr);
        end
        go_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        idle_enable = 1'b1;
        hold_sink = 1'b0;
        hold_cycles = 0;
        shard_setting = 7'd4;
        clear_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        write_shard_count(7'd1);
        test_random(100);
        write_shard_count(7'd64);
        test_random(100);
        write_shard_count(7'd0);
        test_random(50);
        write_shard_count(7'd127);
        test_random(50);
        write_shard_count(7'($urandom_range(2, 63)));
        idle_enable = 1'b0;
        test_random(100);

        go_idle();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- symmetric_flow_hash_steering.f -----
+incdir+hw/rtl
hw/rtl/sfh_pkg.sv
hw/rtl/sfh_parser.sv
hw/rtl/sfh_engine.sv
hw/rtl/symmetric_flow_hash_steering.sv
hw/rtl/sfh_checker.sv
verif/tb_symmetric_flow_hash_steering.sv
